// ===== sv/round_robin_dispatcher_defines.svh =====
// assertion macros used by the dispatcher datapath
`ifndef ROUND_ROBIN_DISPATCHER_DEFINES_SVH
`define ROUND_ROBIN_DISPATCHER_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define RRD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rrd_pkg.sv =====
// types and constants shared by the round-robin dispatcher
package rrd_pkg;

    localparam int TIME_W  = 16;
    localparam int CLK_W   = 21;
    localparam int PID_W   = 5;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CLK_W-1:0] CLOCK_MAX = {CLK_W{1'b1}};

    // register index codes
    localparam logic [PADDR_W-3:0] REG_TIME_SLICE = 1'b0;

    // input function codes
    localparam logic FUNC_LOAD     = 1'b0;
    localparam logic FUNC_DISPATCH = 1'b1;

    typedef struct packed {
        logic load;
        logic arr_nta;
        logic jump;
        logic take;
        logic pop;
        logic run;
        logic post;
        logic emit;
        logic emit_done;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic pending;
        logic arr_le;
    } t_stat;

endpackage

// ===== sv/rrd_datapath.sv =====
// datapath: process stores, ready queue, clock and result registers
`include "round_robin_dispatcher_defines.svh"

module rrd_datapath #(
    parameter int MAX_PROCS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rrd_pkg::t_cmd                 i_cmd,
    output rrd_pkg::t_stat                o_stat,
    input  logic [rrd_pkg::TIME_W-1:0]    i_arrival_time,
    input  logic [rrd_pkg::TIME_W-1:0]    i_burst_time,
    input  logic [rrd_pkg::TIME_W-1:0]    i_time_slice,
    output logic                          o_valid,
    output logic [rrd_pkg::PID_W-1:0]     o_process_id,
    output logic [rrd_pkg::CLK_W-1:0]     o_slice_end_time,
    output logic                          o_finished,
    output logic [rrd_pkg::CLK_W-1:0]     o_turnaround,
    output logic [rrd_pkg::CLK_W-1:0]     o_waiting,
    output logic                          o_all_done
);

    localparam int IDW = $clog2(MAX_PROCS);
    localparam int CNW = $clog2(MAX_PROCS + 1);
    localparam logic [CNW-1:0] MAXC = CNW'(MAX_PROCS);
    localparam logic [CNW:0]   MAXW = (CNW + 1)'(MAX_PROCS);
    localparam logic [IDW-1:0] LAST = IDW'(MAX_PROCS - 1);
    localparam int TW = rrd_pkg::TIME_W;
    localparam int CW = rrd_pkg::CLK_W;
    localparam int PID_W_L = rrd_pkg::PID_W;

    logic [TW-1:0]  mem_arr  [MAX_PROCS];
    logic [TW-1:0]  mem_orig [MAX_PROCS];
    logic [TW-1:0]  mem_rem  [MAX_PROCS];
    logic [IDW-1:0] mem_fifo [MAX_PROCS];

    logic [IDW-1:0] r_head,    n_head;
    logic [CNW-1:0] r_count,   n_count;
    logic [CNW-1:0] r_loaded,  n_loaded;
    logic [CNW-1:0] r_nta,     n_nta;
    logic [CW-1:0]  r_clock,   n_clock;
    logic           r_started, n_started;
    logic           r_o_valid;

    logic [TW-1:0]  r_arr_rd;
    logic [TW-1:0]  r_rem_rd;
    logic [TW-1:0]  r_orig_rd;
    logic [IDW-1:0] r_fifo_rd;
    logic [IDW-1:0] r_id;
    logic [TW-1:0]  r_arr_id;
    logic           r_fin;
    logic [CW-1:0]  r_tat;

    logic [PID_W_L-1:0] r_o_pid;
    logic [CW-1:0]  r_o_end;
    logic           r_o_fin;
    logic [CW-1:0]  r_o_tat;
    logic [CW-1:0]  r_o_wt;
    logic           r_o_all_done;

    logic           w_load_ok;
    logic [CNW:0]   w_tail_sum;
    logic [IDW-1:0] w_tail;
    logic           w_push;
    logic           w_push_ok;
    logic [IDW-1:0] w_push_id;
    logic [IDW-1:0] w_arr_addr;
    logic [TW-1:0]  w_q;
    logic [TW-1:0]  w_run;
    logic [TW-1:0]  w_rem_new;
    logic [CW:0]    w_sum;
    logic           w_rem_we;
    logic [IDW-1:0] w_rem_addr;
    logic [TW-1:0]  w_rem_wd;
    logic [CW-1:0]  w_arr_ext;
    logic [CW-1:0]  w_arr_id_ext;
    logic [CW-1:0]  w_orig_ext;
    logic [CW-1:0]  w_wt;

    assign w_load_ok    = i_cmd.load && (r_loaded < MAXC);
    assign w_tail_sum   = (CNW + 1)'(r_head) + (CNW + 1)'(r_count);
    assign w_tail       = (w_tail_sum >= MAXW) ? IDW'(w_tail_sum - MAXW) : IDW'(w_tail_sum);
    assign w_push       = i_cmd.take || (i_cmd.post && !r_fin);
    assign w_push_ok    = w_push && (r_count < MAXC);
    assign w_push_id    = i_cmd.take ? r_nta[IDW-1:0] : r_id;
    assign w_arr_addr   = i_cmd.arr_nta ? r_nta[IDW-1:0] : r_id;

    assign w_q          = (i_time_slice == '0) ? TW'(1) : i_time_slice;
    assign w_run        = (r_rem_rd < w_q) ? r_rem_rd : w_q;
    assign w_rem_new    = r_rem_rd - w_run;
    assign w_sum        = (CW + 1)'(r_clock) + (CW + 1)'(w_run);
    assign w_rem_we     = w_load_ok || i_cmd.run;
    assign w_rem_addr   = i_cmd.run ? r_id : r_loaded[IDW-1:0];
    assign w_rem_wd     = i_cmd.run ? w_rem_new : i_burst_time;

    assign w_arr_ext    = CW'(r_arr_rd);
    assign w_arr_id_ext = CW'(r_arr_id);
    assign w_orig_ext   = CW'(r_orig_rd);
    assign w_wt         = (r_tat > w_orig_ext) ? (r_tat - w_orig_ext) : '0;

    assign o_stat.empty   = (r_count == '0);
    assign o_stat.pending = (r_nta < r_loaded);
    assign o_stat.arr_le  = (w_arr_ext <= r_clock);

    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_loaded  = r_loaded;
        n_nta     = r_nta;
        n_clock   = r_clock;
        n_started = r_started;
        if (w_load_ok) begin
            n_loaded = r_loaded + CNW'(1);
        end
        if (i_cmd.pop) begin
            n_head  = (r_head == LAST) ? '0 : r_head + IDW'(1);
            n_count = r_count - CNW'(1);
        end
        if (w_push_ok) begin
            n_count = r_count + CNW'(1);
        end
        if (i_cmd.take) begin
            n_nta = r_nta + CNW'(1);
        end
        if (i_cmd.jump) begin
            n_started = 1'b1;
            if (!r_started || (w_arr_ext > r_clock)) begin
                n_clock = w_arr_ext;
            end
        end
        if (i_cmd.run) begin
            n_clock = w_sum[CW] ? rrd_pkg::CLOCK_MAX : w_sum[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_count   <= '0;
            r_loaded  <= '0;
            r_nta     <= '0;
            r_clock   <= '0;
            r_started <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_count   <= n_count;
            r_loaded  <= n_loaded;
            r_nta     <= n_nta;
            r_clock   <= n_clock;
            r_started <= n_started;
            r_o_valid <= i_cmd.emit || i_cmd.emit_done;
        end
    end

    // stores, read data registered
    always_ff @(posedge i_clk) begin
        if (w_load_ok) begin
            mem_arr[r_loaded[IDW-1:0]]  <= i_arrival_time;
            mem_orig[r_loaded[IDW-1:0]] <= i_burst_time;
        end
        if (w_rem_we) begin
            mem_rem[w_rem_addr] <= w_rem_wd;
        end
        if (w_push_ok) begin
            mem_fifo[w_tail] <= w_push_id;
        end
        r_arr_rd  <= mem_arr[w_arr_addr];
        r_rem_rd  <= mem_rem[r_id];
        r_orig_rd <= mem_orig[r_id];
        r_fifo_rd <= mem_fifo[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_id <= r_fifo_rd;
        end
        if (i_cmd.run) begin
            r_arr_id <= r_arr_rd;
            r_fin    <= (w_rem_new == '0);
        end
        if (i_cmd.post) begin
            r_tat <= (r_clock > w_arr_id_ext) ? (r_clock - w_arr_id_ext) : '0;
        end
        if (i_cmd.emit) begin
            r_o_pid      <= PID_W_L'((IDW + 1)'(r_id) + (IDW + 1)'(1));
            r_o_end      <= r_clock;
            r_o_fin      <= r_fin;
            r_o_tat      <= r_fin ? r_tat : '0;
            r_o_wt       <= r_fin ? w_wt : '0;
            r_o_all_done <= 1'b0;
        end else if (i_cmd.emit_done) begin
            r_o_pid      <= '0;
            r_o_end      <= '0;
            r_o_fin      <= 1'b0;
            r_o_tat      <= '0;
            r_o_wt       <= '0;
            r_o_all_done <= 1'b1;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_process_id     = r_o_pid;
    assign o_slice_end_time = r_o_end;
    assign o_finished       = r_o_fin;
    assign o_turnaround     = r_o_tat;
    assign o_waiting        = r_o_wt;
    assign o_all_done       = r_o_all_done;

    `RRD_ASSERT_NOW(a_count_max, 1'b1, r_count <= MAXC, "ready queue count above capacity")
    `RRD_ASSERT_NOW(a_admit_order, 1'b1, r_nta <= r_loaded, "admission ran past loaded processes")
    `RRD_ASSERT_NOW(a_pop_nonempty, i_cmd.pop, r_count != '0, "pop from an empty ready queue")
    `RRD_ASSERT_NEXT(a_clock_mono, i_rst_n, r_clock >= $past(r_clock), "scheduler clock went back")

endmodule

// ===== sv/rrd_ctrl.sv =====
// controller: sequences loads, admission walks and dispatch slices
module rrd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_func,
    input  rrd_pkg::t_stat i_stat,
    output rrd_pkg::t_cmd  o_cmd,
    output logic           o_busy
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DISP    = 4'd1;
    localparam logic [3:0] S_PRE_RD  = 4'd2;
    localparam logic [3:0] S_PRE_JMP = 4'd3;
    localparam logic [3:0] S_ADM_RD  = 4'd4;
    localparam logic [3:0] S_ADM_CMP = 4'd5;
    localparam logic [3:0] S_CHK     = 4'd6;
    localparam logic [3:0] S_RUN_RD  = 4'd7;
    localparam logic [3:0] S_RUN     = 4'd8;
    localparam logic [3:0] S_POST    = 4'd9;
    localparam logic [3:0] S_OUT     = 4'd10;

    logic [3:0] r_state, n_state;
    logic       r_post, n_post;
    logic [3:0] w_adm_exit;

    assign w_adm_exit = r_post ? S_POST : S_CHK;
    assign o_busy     = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_post  = r_post;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_func == rrd_pkg::FUNC_DISPATCH) begin
                        n_state = S_DISP;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_DISP: begin
                if (i_stat.empty && i_stat.pending) begin
                    n_state = S_PRE_RD;
                end else if (i_stat.empty) begin
                    o_cmd.emit_done = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_RUN_RD;
                end
            end
            S_PRE_RD: begin
                o_cmd.arr_nta = 1'b1;
                n_state       = S_PRE_JMP;
            end
            S_PRE_JMP: begin
                o_cmd.jump = 1'b1;
                n_post     = 1'b0;
                n_state    = S_ADM_RD;
            end
            S_ADM_RD: begin
                if (i_stat.pending) begin
                    o_cmd.arr_nta = 1'b1;
                    n_state       = S_ADM_CMP;
                end else begin
                    n_state = w_adm_exit;
                end
            end
            S_ADM_CMP: begin
                if (i_stat.arr_le) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_ADM_RD;
                end else begin
                    n_state = w_adm_exit;
                end
            end
            S_CHK: begin
                if (i_stat.empty) begin
                    o_cmd.emit_done = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_RUN_RD;
                end
            end
            S_RUN_RD: begin
                n_state = S_RUN;
            end
            S_RUN: begin
                o_cmd.run = 1'b1;
                n_post    = 1'b1;
                n_state   = S_ADM_RD;
            end
            S_POST: begin
                o_cmd.post = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_post  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_post  <= n_post;
        end
    end

endmodule

// ===== sv/round_robin_dispatcher.sv =====
// top level of the round-robin dispatcher: register port, controller and datapath
//
//  channel   direction  handshake                    payload
//  command   in         start, busy                  i_func, i_arrival_time, i_burst_time
//  result    out        o_valid (one-cycle strobe)   o_process_id .. o_all_done
//  register  in/out     psel, penable, pwrite, pready  paddr, pwdata, prdata
//
//  a load is taken while idle; busy stays low
//  a dispatch pops the queue head, runs a slice of it, walks admission, requeues it if
//  unfinished and emits; the walk stops at a process not yet arrived; an empty queue
//  with work pending adds a first walk for the jump to the next arrival; an all-done
//  word is emitted when no work is left; the walk reads the arrival store, one read port
//  synchronous active-low reset; the process stores need no clearing
//  the result strobe comes in the same cycle that busy falls and is never held off
module round_robin_dispatcher #(
    parameter int MAX_PROCS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_func,
    input  logic [rrd_pkg::TIME_W-1:0]     i_arrival_time,
    input  logic [rrd_pkg::TIME_W-1:0]     i_burst_time,
    output logic                           o_valid,
    output logic [rrd_pkg::PID_W-1:0]      o_process_id,
    output logic [rrd_pkg::CLK_W-1:0]      o_slice_end_time,
    output logic                           o_finished,
    output logic [rrd_pkg::CLK_W-1:0]      o_turnaround,
    output logic [rrd_pkg::CLK_W-1:0]      o_waiting,
    output logic                           o_all_done,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rrd_pkg::PADDR_W-1:0]    paddr,
    input  logic [rrd_pkg::PDATA_W-1:0]    pwdata,
    output logic [rrd_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);

    logic [rrd_pkg::TIME_W-1:0] r_time_slice;
    logic                       w_reg_sel;
    rrd_pkg::t_cmd              w_cmd;
    rrd_pkg::t_stat             w_stat;

    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[rrd_pkg::PADDR_W-1:2] == rrd_pkg::REG_TIME_SLICE);
    assign prdata    = w_reg_sel ? rrd_pkg::PDATA_W'(r_time_slice) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_slice <= rrd_pkg::TIME_W'(1);
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_time_slice <= pwdata[rrd_pkg::TIME_W-1:0];
        end
    end

    rrd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    rrd_datapath #(
        .MAX_PROCS (MAX_PROCS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_arrival_time   (i_arrival_time),
        .i_burst_time     (i_burst_time),
        .i_time_slice     (r_time_slice),
        .o_valid          (o_valid),
        .o_process_id     (o_process_id),
        .o_slice_end_time (o_slice_end_time),
        .o_finished       (o_finished),
        .o_turnaround     (o_turnaround),
        .o_waiting        (o_waiting),
        .o_all_done       (o_all_done)
    );

endmodule
